>>> rtl/assert_macros.svh
// Assertion macros used by the allocator top level.
// Unless SYNTH is defined, each macro checks a property on the rising clock edge and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/pba_pkg.sv
package pba_pkg;

   // Map geometry.
   localparam int MAP_WORDS   = 16;
   localparam int WORD_BITS   = 32;
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int PAGE_W      = WORD_IDX_W + BIT_IDX_W;
   localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;
   localparam int COUNT_W     = PAGE_W + 1;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

   // Sequencer states.
   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_INIT     = 7'b0000010,
      S_ALLOC_RD = 7'b0000100,
      S_ALLOC_CK = 7'b0001000,
      S_FREE_RD  = 7'b0010000,
      S_FREE_CK  = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   // Everything the word unit derives from one map word.
   typedef struct packed {
      logic                 any;
      logic [BIT_IDX_W-1:0] low_bit;
      logic [WORD_BITS-1:0] cleared;
      logic [WORD_BITS-1:0] with_set;
      logic                 bit_set;
      logic [WORD_BITS-1:0] init_mask;
   } word_res_type;

endpackage

>>> rtl/pba_ram.sv
module pba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pba_word_unit.sv
module pba_word_unit (
   input  logic [pba_pkg::WORD_BITS-1:0]  word,
   input  logic [pba_pkg::BIT_IDX_W-1:0]  bit_sel,
   input  logic [pba_pkg::WORD_IDX_W-1:0] word_idx,
   input  logic [pba_pkg::COUNT_W-1:0]    first_page,
   output pba_pkg::word_res_type          res
);

   import pba_pkg::*;

   logic [BIT_IDX_W-1:0]           low_bit;
   logic [COUNT_W-BIT_IDX_W-1:0]   first_word;
   logic [COUNT_W-BIT_IDX_W-1:0]   this_word;

   // Lowest set bit of the word; the scan runs downward so the lowest wins.
   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            low_bit = BIT_IDX_W'(i);
         end
      end
   end

   assign first_word = first_page[COUNT_W-1:BIT_IDX_W];
   assign this_word  = (COUNT_W - BIT_IDX_W)'(word_idx);

   // Bit edits and the init pattern for the addressed word.
   always_comb begin
      res.any      = |word;
      res.low_bit  = low_bit;
      res.cleared  = word & ~(WORD_BITS'(1) << low_bit);
      res.with_set = word | (WORD_BITS'(1) << bit_sel);
      res.bit_set  = word[bit_sel];
      if (first_word > this_word) begin
         res.init_mask = '0;
      end else if (first_word == this_word) begin
         res.init_mask = {WORD_BITS{1'b1}} << first_page[BIT_IDX_W-1:0];
      end else begin
         res.init_mask = {WORD_BITS{1'b1}};
      end
   end

endmodule

>>> rtl/page_bitmap_allocator_top.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_op, req_page
// rsp       out        rsp_valid/rsp_ready  rsp_status, rsp_alloc_page, rsp_free_count
// csr       in         csr_we               csr_wdata (first free page)
//
// One word is taken at a time; the map RAM's registered read sets the pace.
// Init writes one map word per cycle.
// Allocate reads and checks up to MAP_WORDS words in turn; free checks one word.
// After reset every page is in use; the map needs no clearing pass.
// A new word is accepted while the previous result still waits on rsp_ready.
module page_bitmap_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pba_pkg::OP_W-1:0]       req_op,
   input  logic [pba_pkg::PAGE_W-1:0]     req_page,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pba_pkg::PAGE_W-1:0]     rsp_alloc_page,
   output logic [pba_pkg::COUNT_W-1:0]    rsp_free_count,
   input  logic                           csr_we,
   input  logic [pba_pkg::COUNT_W-1:0]    csr_wdata
);

   import pba_pkg::*;

`include "assert_macros.svh"

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      first_ff;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [WORD_IDX_W-1:0]   search_ff, search_in;
   logic [WORD_IDX_W-1:0]   idx_ff, idx_in;
   logic [WORD_IDX_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [PAGE_W-1:0]       res_page_ff, res_page_in;
   logic [MAP_WORDS-1:0]    valid_ff, valid_in;
   logic                    rd_valid_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [PAGE_W-1:0]       rsp_page_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   logic                    wr_en;
   logic [WORD_IDX_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0]    wr_data;
   logic [WORD_IDX_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0]    rd_data;
   logic [WORD_BITS-1:0]    rd_word;
   logic [WORD_IDX_W-1:0]   page_word;
   logic                    rsp_load;
   logic [WORD_IDX_W-1:0]   idx_next;
   word_res_type            wu_res;

   assign page_word = page_ff[PAGE_W-1:BIT_IDX_W];
   assign idx_next  = (idx_ff == WORD_IDX_W'(MAP_WORDS - 1)) ? '0 : idx_ff + 1'b1;

   // Map storage; a word never written since reset reads as all in use.
   pba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = (state_ff == S_FREE_RD) ? page_word : idx_ff;
   assign rd_word = rd_valid_ff ? rd_data : '0;

   // Shared unit that works on the word just read and builds the init pattern.
   pba_word_unit u_word (
      .word       (rd_word),
      .bit_sel    (page_ff[BIT_IDX_W-1:0]),
      .word_idx   (idx_ff),
      .first_page (first_ff),
      .res        (wu_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      search_in     = search_ff;
      idx_in        = idx_ff;
      scan_cnt_in   = scan_cnt_ff;
      page_in       = page_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      valid_in      = valid_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = wu_res.init_mask;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               page_in       = req_page;
               res_status_in = ST_OK;
               res_page_in   = '0;
               case (req_op)
                  OP_INIT: begin
                     idx_in   = '0;
                     state_in = S_INIT;
                  end
                  OP_ALLOC: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        idx_in      = search_ff;
                        scan_cnt_in = '0;
                        state_in    = S_ALLOC_RD;
                     end
                  end
                  OP_FREE: begin
                     state_in = S_FREE_RD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INIT: begin
            wr_en            = 1'b1;
            wr_addr          = idx_ff;
            wr_data          = wu_res.init_mask;
            valid_in[idx_ff] = 1'b1;
            idx_in           = idx_next;
            if (idx_ff == WORD_IDX_W'(MAP_WORDS - 1)) begin
               if (first_ff >= COUNT_W'(TOTAL_PAGES)) begin
                  count_in = '0;
               end else begin
                  count_in = COUNT_W'(TOTAL_PAGES) - first_ff;
               end
               state_in = S_DONE;
            end
         end
         S_ALLOC_RD: begin
            state_in = S_ALLOC_CK;
         end
         S_ALLOC_CK: begin
            if (wu_res.any) begin
               wr_en            = 1'b1;
               wr_addr          = idx_ff;
               wr_data          = wu_res.cleared;
               valid_in[idx_ff] = 1'b1;
               search_in        = idx_ff;
               count_in         = count_ff - 1'b1;
               res_page_in      = {idx_ff, wu_res.low_bit};
               state_in         = S_DONE;
            end else if (scan_cnt_ff == WORD_IDX_W'(MAP_WORDS - 1)) begin
               res_status_in = ST_EMPTY;
               state_in      = S_DONE;
            end else begin
               idx_in      = idx_next;
               scan_cnt_in = scan_cnt_ff + 1'b1;
               state_in    = S_ALLOC_RD;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_CK;
         end
         S_FREE_CK: begin
            if ((COUNT_W'(page_ff) >= COUNT_W'(TOTAL_PAGES)) || wu_res.bit_set) begin
               res_status_in = ST_BADFREE;
            end else begin
               wr_en               = 1'b1;
               wr_addr             = page_word;
               wr_data             = wu_res.with_set;
               valid_in[page_word] = 1'b1;
               count_in            = count_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= '0;
         count_ff     <= '0;
         search_ff    <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         search_ff    <= search_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= valid_ff[rd_addr];
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            first_ff <= csr_wdata;
         end
      end
   end

   // Working and result payload.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      scan_cnt_ff   <= scan_cnt_in;
      page_ff       <= page_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_page_ff   <= res_page_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_alloc_page = rsp_page_ff;
   assign rsp_free_count = rsp_count_ff;

   // The free count never exceeds the number of pages in the map.
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= COUNT_W'(TOTAL_PAGES))

   // A successful allocation takes exactly one page from the count.
   `ASSERT_NEXT(a_alloc_count, clock, reset, (state_ff == S_ALLOC_CK) && wu_res.any,
      count_ff == $past(count_ff) - 1'b1)

   // A failed allocation always reports page zero.
   `ASSERT_SAME(a_empty_page, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_EMPTY),
      rsp_page_ff == '0)

endmodule

>>> verif/page_bitmap_allocator_top_tb.sv
`timescale 1ns / 100ps

module page_bitmap_allocator_top_tb;
   import pba_pkg::*;

   // The op code that the block treats as a no-operation.
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned SETTLE_CYCLES = 2 * MAP_WORDS + 8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   alloc_page;
      logic [COUNT_W-1:0]  free_count;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [PAGE_W-1:0]   req_page;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [PAGE_W-1:0]   rsp_alloc_page;
   logic [COUNT_W-1:0]  rsp_free_count;
   logic                csr_we;
   logic [COUNT_W-1:0]  csr_wdata;

   // Shadow copy of the allocator state, advanced as each word is accepted.
   logic [WORD_BITS-1:0]  shadow_map [MAP_WORDS];
   logic [WORD_IDX_W-1:0] shadow_ptr;
   int unsigned           shadow_free;
   logic [COUNT_W-1:0]    shadow_first;

   outcome_type expected_outcomes [$];
   int unsigned mismatches;
   logic        valid_up;
   logic        no_stall;

   page_bitmap_allocator_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_page       (req_page),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_alloc_page (rsp_alloc_page),
      .rsp_free_count (rsp_free_count),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Computes the outcome of one request and updates the shadow state.
   function automatic outcome_type apply_request(logic [OP_W-1:0] op,
                                                 logic [PAGE_W-1:0] page);
      outcome_type res;
      int unsigned w;
      int unsigned b;
      int unsigned i;
      int unsigned idx;
      logic        found;
      res = '0;
      res.status = ST_OK;
      case (op)
         OP_INIT: begin
            shadow_free = 0;
            for (w = 0; w < MAP_WORDS; w++) begin
               for (b = 0; b < WORD_BITS; b++) begin
                  shadow_map[w][b] = (w * WORD_BITS + b >= shadow_first);
                  if (shadow_map[w][b]) begin
                     shadow_free++;
                  end
               end
            end
         end
         OP_ALLOC: begin
            res.status = ST_EMPTY;
            found = 1'b0;
            if (shadow_free != 0) begin
               // Scan from the pointer with wrap-around; take the lowest set bit.
               for (i = 0; i < MAP_WORDS && !found; i++) begin
                  idx = (shadow_ptr + i) % MAP_WORDS;
                  if (shadow_map[idx] != '0) begin
                     b = 0;
                     while (!shadow_map[idx][b]) begin
                        b++;
                     end
                     shadow_map[idx][b] = 1'b0;
                     shadow_ptr = idx[WORD_IDX_W-1:0];
                     shadow_free--;
                     res.status = ST_OK;
                     res.alloc_page = PAGE_W'(idx * WORD_BITS + b);
                     found = 1'b1;
                  end
               end
            end
         end
         OP_FREE: begin
            w = page / WORD_BITS;
            b = page % WORD_BITS;
            if (page >= TOTAL_PAGES || shadow_map[w][b]) begin
               res.status = ST_BADFREE;
            end else begin
               shadow_map[w][b] = 1'b1;
               shadow_free++;
            end
         end
         default: begin
         end
      endcase
      res.free_count = COUNT_W'(shadow_free);
      return res;
   endfunction

   // Picks a page that is currently in use, searching from a random start.
   function automatic logic [PAGE_W-1:0] pick_used_page();
      int unsigned start;
      int unsigned k;
      int unsigned p;
      start = $urandom_range(TOTAL_PAGES - 1);
      for (k = 0; k < TOTAL_PAGES; k++) begin
         p = (start + k) % TOTAL_PAGES;
         if (!shadow_map[p / WORD_BITS][p % WORD_BITS]) begin
            return PAGE_W'(p);
         end
      end
      return PAGE_W'(start);
   endfunction

   task automatic drop_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
   endtask

   // Sends one word on the request channel and records its outcome once accepted.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page);
      while (!no_stall && $urandom_range(99) < 26) begin
         drop_valid();
         @(posedge clock);
      end
      req_valid <= 1'b1;
      valid_up = 1'b1;
      req_op <= op;
      req_page <= page;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_outcomes.push_back(apply_request(op, page));
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic wait_until_drained();
      drop_valid();
      do begin
         @(posedge clock);
      end while (expected_outcomes.size() != 0);
   endtask

   // The block is idle here, so the register may change.
   task automatic write_first_free_page(input logic [COUNT_W-1:0] value);
      wait_until_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      shadow_first = value;
      csr_we <= 1'b0;
   endtask

   // Mostly allocations and frees of pages in use, with some noise mixed in.
   task automatic run_mixed_traffic(input int unsigned count, input int unsigned alloc_pct);
      int unsigned n;
      int unsigned r;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < alloc_pct) begin
            send_word(OP_ALLOC, PAGE_W'($urandom));
         end else if (r < alloc_pct + (100 - alloc_pct) * 2 / 3) begin
            send_word(OP_FREE, pick_used_page());
         end else if (r < 94) begin
            send_word(OP_FREE, PAGE_W'($urandom));
         end else if (r < 98) begin
            send_word(OP_INIT, PAGE_W'($urandom));
         end else begin
            send_word(OP_SPARE, PAGE_W'($urandom));
         end
      end
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] first, input int unsigned count,
                            input int unsigned alloc_pct);
      write_first_free_page(first);
      send_word(OP_INIT, PAGE_W'($urandom));
      run_mixed_traffic(count, alloc_pct);
   endtask

   // Reset state, bad frees, wrap of the search pointer and the register extremes.
   task automatic test_directed_cases();
      send_word(OP_ALLOC, '0);
      send_word(OP_FREE, 9'd511);
      send_word(OP_ALLOC, '0);
      send_word(OP_SPARE, 9'd511);
      send_word(OP_FREE, 9'd0);
      send_word(OP_FREE, 9'd0);
      write_first_free_page(10'd0);
      send_word(OP_INIT, '0);
      send_word(OP_FREE, 9'd100);
      send_word(OP_ALLOC, 9'h1FF);
      send_word(OP_ALLOC, '0);
      send_word(OP_FREE, 9'd480);
      send_word(OP_ALLOC, '0);
      // Init must leave the search pointer where it was.
      send_word(OP_INIT, '0);
      send_word(OP_ALLOC, '0);
      // A start beyond the map leaves every page in use.
      write_first_free_page(10'd512);
      send_word(OP_INIT, '0);
      send_word(OP_ALLOC, '0);
      send_word(OP_FREE, 9'h155);
      send_word(OP_FREE, 9'h0AA);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);
      write_first_free_page(10'd511);
      send_word(OP_INIT, '0);
      send_word(OP_ALLOC, '0);
      send_word(OP_ALLOC, '0);
   endtask

   task automatic test_mixed_phases();
      run_phase(10'd0, 150, 45);
      run_phase(10'd512, 100, 40);
      run_phase(COUNT_W'($urandom_range(1, 511)), 150, 50);
      run_phase(10'd1, 150, 45);
   endtask

   // Small pools and heavy allocation, so the allocator runs dry often.
   task automatic test_exhaustion();
      run_phase(10'd480, 120, 70);
      run_phase(10'd384, 150, 75);
   endtask

   task automatic test_no_stall_stretch();
      no_stall = 1'b1;
      run_phase(10'd256, 200, 50);
      no_stall = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      int unsigned burst;
      write_first_free_page(COUNT_W'($urandom_range(0, 512)));
      send_word(OP_INIT, '0);
      for (burst = 0; burst < 6; burst++) begin
         run_mixed_traffic(15, 50);
         wait_until_drained();
      end
   endtask

   task automatic note_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %0s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // Receiver side: random back-pressure, except in the stretch without stalls.
   always @(posedge clock) begin
      rsp_ready <= no_stall || ($urandom_range(99) >= 26);
   end

   // Each accepted result is compared with the oldest outstanding outcome.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result word with no request outstanding");
            end
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               note_mismatch("status", 16'(want.status), 16'(rsp_status));
            end
            if (rsp_alloc_page !== want.alloc_page) begin
               note_mismatch("alloc_page", 16'(want.alloc_page), 16'(rsp_alloc_page));
            end
            if (rsp_free_count !== want.free_count) begin
               note_mismatch("free_count", 16'(want.free_count), 16'(rsp_free_count));
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("page_bitmap_allocator_top_tb failed");
      $finish;
   end

   initial begin
      int unsigned w;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_INIT;
      req_page <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      valid_up = 1'b0;
      no_stall = 1'b0;
      mismatches = 0;
      for (w = 0; w < MAP_WORDS; w++) begin
         shadow_map[w] = '0;
      end
      shadow_ptr = '0;
      shadow_free = 0;
      shadow_first = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_mixed_phases();
      test_exhaustion();
      test_no_stall_stretch();
      test_pause_until_drained();

      // Let everything drain, then allow for a longest scan before the verdict.
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("page_bitmap_allocator_top_tb passed");
      end else begin
         $display("page_bitmap_allocator_top_tb failed");
      end
      $finish;
   end

endmodule
